@@ design/hmg_pkg.sv @@
// shared types and constants for the histogram matching unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package hmg_pkg;

   localparam int BINS  = 256;
   localparam int BIN_W = 8;

   localparam logic [1:0] MODE_CLEAR  = 2'd0;
   localparam logic [1:0] MODE_SRC    = 2'd1;
   localparam logic [1:0] MODE_TGT    = 2'd2;
   localparam logic [1:0] MODE_REMAP  = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CNT_RD,
      ST_CNT_WR,
      ST_BLD_INIT,
      ST_BLD_ZERO,
      ST_LOAD_RD,
      ST_LOAD_ACC,
      ST_LOAD_MUL,
      ST_LOAD_PUSH,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE,
      ST_REMAP_RD,
      ST_REMAP_OUT
   } state_type;

endpackage
`default_nettype wire

@@ design/hmg_ram.sv @@
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module hmg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ design/hmg_cell.sv @@
// one cell of the nearest-fraction search chain: holds one target bin,
// compares it with the passing source stream; uses hmg_pkg
`timescale 1ns / 1ps
`default_nettype none
module hmg_cell #(
   parameter int PW = 50
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       shift,
   input  wire logic [PW-1:0]              best_init,
   input  wire logic [PW-1:0]              prev_a,
   input  wire logic [hmg_pkg::BIN_W-1:0]  prev_i,
   input  wire logic                       prev_v,
   input  wire logic [hmg_pkg::BIN_W-1:0]  prev_end,
   input  wire logic [PW-1:0]              str_b,
   input  wire logic [hmg_pkg::BIN_W-1:0]  str_j,
   input  wire logic                       str_v,
   output logic      [PW-1:0]              a,
   output logic      [hmg_pkg::BIN_W-1:0]  i,
   output logic                            v,
   output logic      [hmg_pkg::BIN_W-1:0]  end_j,
   output logic      [PW-1:0]              out_b,
   output logic      [hmg_pkg::BIN_W-1:0]  out_j,
   output logic                            out_v
);

   logic [PW-1:0]             a_ff, best_ff, best_in, b_ff, diff;
   logic [hmg_pkg::BIN_W-1:0] i_ff, end_ff, end_in, j_ff;
   logic                      v_ff, sv_ff;

   always_comb begin
      diff    = (a_ff >= str_b) ? (a_ff - str_b) : (str_b - a_ff);
      best_in = best_ff;
      end_in  = end_ff;
      if (shift) begin
         best_in = best_init;
         end_in  = prev_end;
      end else if (str_v && v_ff && (diff < best_ff)) begin
         best_in = diff;
         end_in  = str_j;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff  <= 1'b0;
         sv_ff <= 1'b0;
      end else begin
         if (shift) begin
            v_ff <= prev_v;
         end
         sv_ff <= str_v;
      end
      if (shift) begin
         a_ff <= prev_a;
         i_ff <= prev_i;
      end
      best_ff <= best_in;
      end_ff  <= end_in;
      b_ff    <= str_b;
      j_ff    <= str_j;
   end

   assign a     = a_ff;
   assign i     = i_ff;
   assign v     = v_ff;
   assign end_j = end_ff;
   assign out_b = b_ff;
   assign out_j = j_ff;
   assign out_v = sv_ff;

endmodule
`default_nettype wire

@@ design/histogram_matching_gml_unit.sv @@
// top level: histogram counting, table build by a chain of search cells, remap
// uses hmg_pkg, hmg_ram, hmg_cell
// steps: clear zeroes every bin and map entry; a count reads a bin and writes it back plus one;
// a remap reads the map, then returns the result; the first remap after a load first
// zeroes the map, then loads passes of up to CELLS target bins, scans and writes the table
// one transaction at a time: req_stall is high whenever the state machine is not idle
// reset: synchronous, runs a clearing pass over all 256 bins before the first transaction
`timescale 1ns / 1ps
`default_nettype none
module histogram_matching_gml_unit #(
   parameter logic [32:0] MAX_PIXELS = 33'd16777216,
   parameter int          CELLS      = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_mode,
   input  wire logic [7:0] req_pixel,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_mapped_pixel
);

   localparam int CW  = $clog2(MAX_PIXELS + 1);
   localparam int PW  = 2 * CW;
   localparam int BW  = hmg_pkg::BIN_W;
   localparam int NLW = $clog2(CELLS + 1);
   localparam int SCW = $clog2(hmg_pkg::BINS + CELLS + 3);
   localparam logic [SCW-1:0] SC_LAST = SCW'(hmg_pkg::BINS + CELLS + 2);
   localparam logic [BW-1:0]  BIN_LAST = BW'(hmg_pkg::BINS - 1);

   hmg_pkg::state_type state_ff, state_in;

   logic [1:0]     mode_ff;
   logic [BW-1:0]  pix_ff, cnt_ff, cnt_in, ti_ff, ti_in, wend_ff, wend_in, wi_ff, wi_in;
   logic [BW-1:0]  j1_ff, j2_ff, j3_ff;
   logic [CW-1:0]  src_tot_ff, src_tot_in, tgt_tot_ff, tgt_tot_in;
   logic [CW-1:0]  tcum_ff, tcum_in, scum_ff, scum_in, mul_x, mul_y;
   logic [PW-1:0]  mul_ff, tts_ff;
   logic           built_ff, built_in, tdone_ff, tdone_in;
   logic           v1_ff, v2_ff, v3_ff, rsp_valid_ff, rsp_valid_in;
   logic [NLW-1:0] nl_ff, nl_in, dc_ff, dc_in;
   logic [SCW-1:0] sc_ff, sc_in;
   logic [BW:0]    nstart_ff, nstart_in, wj_ff, wj_in;
   logic [7:0]     rsp_pix_ff, rsp_pix_in;
   logic           acc, rsp_free, shift, wr_active;

   logic [CW-1:0]  src_rd, tgt_rd;
   logic [7:0]     map_rd;
   logic           src_we, tgt_we, map_we;
   logic [BW-1:0]  src_wa, tgt_wa, map_wa, src_ra;
   logic [CW-1:0]  src_wd, tgt_wd;
   logic [7:0]     map_wd;

   logic [PW-1:0]  c_a   [CELLS];
   logic [BW-1:0]  c_i   [CELLS];
   logic [BW-1:0]  c_end [CELLS];
   logic [PW-1:0]  c_b   [CELLS];
   logic [BW-1:0]  c_j   [CELLS];
   logic [CELLS-1:0] c_v, c_sv;

   assign acc       = req_valid && !req_stall;
   assign req_stall = (state_ff != hmg_pkg::ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign shift     = (state_ff == hmg_pkg::ST_LOAD_PUSH) ||
                      ((state_ff == hmg_pkg::ST_DRAIN) && (dc_ff != NLW'(CELLS)));
   assign wr_active = (state_ff == hmg_pkg::ST_WRITE) && (wj_ff <= {1'b0, wend_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hmg_pkg::ST_CLEAR: begin
            if (cnt_ff == BIN_LAST) state_in = hmg_pkg::ST_IDLE;
         end
         hmg_pkg::ST_IDLE: begin
            if (acc) begin
               unique case (req_mode)
                  hmg_pkg::MODE_CLEAR: state_in = hmg_pkg::ST_CLEAR;
                  hmg_pkg::MODE_SRC,
                  hmg_pkg::MODE_TGT:   state_in = hmg_pkg::ST_CNT_RD;
                  default:             state_in = built_ff ? hmg_pkg::ST_REMAP_RD
                                                           : hmg_pkg::ST_BLD_INIT;
               endcase
            end
         end
         hmg_pkg::ST_CNT_RD:   state_in = hmg_pkg::ST_CNT_WR;
         hmg_pkg::ST_CNT_WR:   state_in = hmg_pkg::ST_IDLE;
         hmg_pkg::ST_BLD_INIT: state_in = hmg_pkg::ST_BLD_ZERO;
         hmg_pkg::ST_BLD_ZERO: begin
            if (cnt_ff == BIN_LAST) begin
               state_in = ((src_tot_ff == '0) || (tgt_tot_ff == '0))
                          ? hmg_pkg::ST_REMAP_RD : hmg_pkg::ST_LOAD_RD;
            end
         end
         hmg_pkg::ST_LOAD_RD:  state_in = hmg_pkg::ST_LOAD_ACC;
         hmg_pkg::ST_LOAD_ACC: begin
            if (tgt_rd != '0) begin
               state_in = hmg_pkg::ST_LOAD_MUL;
            end else if (ti_ff == BIN_LAST) begin
               state_in = (nl_ff != '0) ? hmg_pkg::ST_SCAN : hmg_pkg::ST_REMAP_RD;
            end else begin
               state_in = hmg_pkg::ST_LOAD_RD;
            end
         end
         hmg_pkg::ST_LOAD_MUL: state_in = hmg_pkg::ST_LOAD_PUSH;
         hmg_pkg::ST_LOAD_PUSH: begin
            state_in = ((ti_ff == BIN_LAST) || (nl_ff == NLW'(CELLS - 1)))
                       ? hmg_pkg::ST_SCAN : hmg_pkg::ST_LOAD_RD;
         end
         hmg_pkg::ST_SCAN: begin
            if (sc_ff == SC_LAST) state_in = hmg_pkg::ST_DRAIN;
         end
         hmg_pkg::ST_DRAIN: begin
            if (dc_ff == NLW'(CELLS)) begin
               state_in = tdone_ff ? hmg_pkg::ST_REMAP_RD : hmg_pkg::ST_LOAD_RD;
            end else if (c_v[CELLS-1]) begin
               state_in = hmg_pkg::ST_WRITE;
            end
         end
         hmg_pkg::ST_WRITE: begin
            if (!wr_active) state_in = hmg_pkg::ST_DRAIN;
         end
         hmg_pkg::ST_REMAP_RD:  state_in = hmg_pkg::ST_REMAP_OUT;
         hmg_pkg::ST_REMAP_OUT: begin
            if (rsp_free) state_in = hmg_pkg::ST_IDLE;
         end
         default: state_in = hmg_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cnt_in       = ((state_ff == hmg_pkg::ST_CLEAR) || (state_ff == hmg_pkg::ST_BLD_ZERO))
                     ? cnt_ff + 1'b1 : '0;
      src_tot_in   = src_tot_ff;
      tgt_tot_in   = tgt_tot_ff;
      built_in     = built_ff;
      ti_in        = ti_ff;
      tcum_in      = tcum_ff;
      tdone_in     = tdone_ff;
      nl_in        = nl_ff;
      dc_in        = dc_ff;
      nstart_in    = nstart_ff;
      wj_in        = wj_ff;
      wend_in      = wend_ff;
      wi_in        = wi_ff;
      sc_in        = (state_ff == hmg_pkg::ST_SCAN) ? sc_ff + 1'b1 : '0;
      scum_in      = '0;
      mul_x        = tgt_tot_ff;
      mul_y        = src_tot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pix_in   = rsp_pix_ff;

      if (acc && (req_mode == hmg_pkg::MODE_CLEAR)) begin
         src_tot_in = '0;
         tgt_tot_in = '0;
      end
      if (state_ff == hmg_pkg::ST_CNT_WR) begin
         if ((mode_ff == hmg_pkg::MODE_SRC) && (src_tot_ff < CW'(MAX_PIXELS))) begin
            src_tot_in = src_tot_ff + 1'b1;
         end
         if ((mode_ff == hmg_pkg::MODE_TGT) && (tgt_tot_ff < CW'(MAX_PIXELS))) begin
            tgt_tot_in = tgt_tot_ff + 1'b1;
         end
      end

      if (state_in == hmg_pkg::ST_REMAP_RD) begin
         built_in = 1'b1;
      end else if (acc && (req_mode != hmg_pkg::MODE_REMAP)) begin
         built_in = 1'b0;
      end

      unique case (state_ff)
         hmg_pkg::ST_BLD_ZERO: begin
            ti_in     = '0;
            tcum_in   = '0;
            tdone_in  = 1'b0;
            nl_in     = '0;
            dc_in     = '0;
            nstart_in = '0;
         end
         hmg_pkg::ST_LOAD_ACC: begin
            tcum_in = tcum_ff + tgt_rd;
            if (tgt_rd == '0) begin
               if (ti_ff == BIN_LAST) tdone_in = 1'b1;
               else                   ti_in    = ti_ff + 1'b1;
            end
         end
         hmg_pkg::ST_LOAD_MUL: begin
            mul_x = tcum_ff;
            mul_y = src_tot_ff;
         end
         hmg_pkg::ST_LOAD_PUSH: begin
            nl_in = nl_ff + 1'b1;
            if (ti_ff == BIN_LAST) tdone_in = 1'b1;
            else                   ti_in    = ti_ff + 1'b1;
         end
         hmg_pkg::ST_SCAN: begin
            scum_in = v1_ff ? scum_ff + src_rd : scum_ff;
            mul_x   = scum_ff;
            mul_y   = tgt_tot_ff;
         end
         hmg_pkg::ST_DRAIN: begin
            if (dc_ff == NLW'(CELLS)) begin
               dc_in = '0;
               nl_in = '0;
            end else begin
               dc_in = dc_ff + 1'b1;
               if (c_v[CELLS-1]) begin
                  wi_in     = c_i[CELLS-1];
                  wend_in   = c_end[CELLS-1];
                  wj_in     = nstart_ff;
                  nstart_in = {1'b0, c_end[CELLS-1]} + 1'b1;
               end
            end
         end
         hmg_pkg::ST_WRITE: begin
            if (wr_active) wj_in = wj_ff + 1'b1;
         end
         hmg_pkg::ST_REMAP_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = map_rd;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hmg_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         src_tot_ff   <= '0;
         tgt_tot_ff   <= '0;
         built_ff     <= 1'b0;
         tdone_ff     <= 1'b0;
         nl_ff        <= '0;
         dc_ff        <= '0;
         sc_ff        <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         src_tot_ff   <= src_tot_in;
         tgt_tot_ff   <= tgt_tot_in;
         built_ff     <= built_in;
         tdone_ff     <= tdone_in;
         nl_ff        <= nl_in;
         dc_ff        <= dc_in;
         sc_ff        <= sc_in;
         v1_ff        <= (state_ff == hmg_pkg::ST_SCAN) && (sc_ff < SCW'(hmg_pkg::BINS));
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (acc) begin
         mode_ff <= req_mode;
         pix_ff  <= req_pixel;
      end
      if (state_ff == hmg_pkg::ST_BLD_ZERO) begin
         tts_ff <= mul_ff;
      end
      ti_ff      <= ti_in;
      tcum_ff    <= tcum_in;
      scum_ff    <= scum_in;
      nstart_ff  <= nstart_in;
      wj_ff      <= wj_in;
      wend_ff    <= wend_in;
      wi_ff      <= wi_in;
      j1_ff      <= sc_ff[BW-1:0];
      j2_ff      <= j1_ff;
      j3_ff      <= j2_ff;
      mul_ff     <= PW'(mul_x) * PW'(mul_y);
      rsp_pix_ff <= rsp_pix_in;
   end

   // bin and table memories
   always_comb begin
      src_ra = (state_ff == hmg_pkg::ST_SCAN) ? sc_ff[BW-1:0] : pix_ff;
      src_we = (state_ff == hmg_pkg::ST_CLEAR) ||
               ((state_ff == hmg_pkg::ST_CNT_WR) && (mode_ff == hmg_pkg::MODE_SRC) &&
                (src_tot_ff < CW'(MAX_PIXELS)));
      tgt_we = (state_ff == hmg_pkg::ST_CLEAR) ||
               ((state_ff == hmg_pkg::ST_CNT_WR) && (mode_ff == hmg_pkg::MODE_TGT) &&
                (tgt_tot_ff < CW'(MAX_PIXELS)));
      src_wa = (state_ff == hmg_pkg::ST_CLEAR) ? cnt_ff : pix_ff;
      tgt_wa = src_wa;
      src_wd = (state_ff == hmg_pkg::ST_CLEAR) ? '0 : src_rd + 1'b1;
      tgt_wd = (state_ff == hmg_pkg::ST_CLEAR) ? '0 : tgt_rd + 1'b1;
      map_we = (state_ff == hmg_pkg::ST_CLEAR) || (state_ff == hmg_pkg::ST_BLD_ZERO) ||
               wr_active;
      map_wa = wr_active ? wj_ff[BW-1:0] : cnt_ff;
      map_wd = wr_active ? wi_ff : 8'd0;
   end

   hmg_ram #(.WIDTH(CW), .DEPTH(hmg_pkg::BINS)) u_src_ram (
      .clock   (clock),
      .wr_en   (src_we),
      .wr_addr (src_wa),
      .wr_data (src_wd),
      .rd_addr (src_ra),
      .rd_data (src_rd)
   );

   hmg_ram #(.WIDTH(CW), .DEPTH(hmg_pkg::BINS)) u_tgt_ram (
      .clock   (clock),
      .wr_en   (tgt_we),
      .wr_addr (tgt_wa),
      .wr_data (tgt_wd),
      .rd_addr ((state_ff == hmg_pkg::ST_LOAD_RD) ? ti_ff : pix_ff),
      .rd_data (tgt_rd)
   );

   hmg_ram #(.WIDTH(8), .DEPTH(hmg_pkg::BINS)) u_map_ram (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wa),
      .wr_data (map_wd),
      .rd_addr (pix_ff),
      .rd_data (map_rd)
   );

   // search chain
   for (genvar k = 0; k < CELLS; k++) begin : g_cell
      if (k == 0) begin : g_head
         hmg_cell #(.PW(PW)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .best_init (tts_ff),
            .prev_a    (mul_ff),
            .prev_i    (ti_ff),
            .prev_v    (state_ff == hmg_pkg::ST_LOAD_PUSH),
            .prev_end  ({BW{1'b0}}),
            .str_b     (mul_ff),
            .str_j     (j3_ff),
            .str_v     (v3_ff),
            .a         (c_a[k]),
            .i         (c_i[k]),
            .v         (c_v[k]),
            .end_j     (c_end[k]),
            .out_b     (c_b[k]),
            .out_j     (c_j[k]),
            .out_v     (c_sv[k])
         );
      end else begin : g_body
         hmg_cell #(.PW(PW)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .shift     (shift),
            .best_init (tts_ff),
            .prev_a    (c_a[k-1]),
            .prev_i    (c_i[k-1]),
            .prev_v    (c_v[k-1]),
            .prev_end  (c_end[k-1]),
            .str_b     (c_b[k-1]),
            .str_j     (c_j[k-1]),
            .str_v     (c_sv[k-1]),
            .a         (c_a[k]),
            .i         (c_i[k]),
            .v         (c_v[k]),
            .end_j     (c_end[k]),
            .out_b     (c_b[k]),
            .out_j     (c_j[k]),
            .out_v     (c_sv[k])
         );
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mapped_pixel = rsp_pix_ff;

   // a clear transaction restarts the sweep and invalidates the table
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (acc && (req_mode == hmg_pkg::MODE_CLEAR)) |=>
      ((state_ff == hmg_pkg::ST_CLEAR) && !built_ff && (src_tot_ff == '0)))
      else $error("clear transaction not applied");

   // every load pass starts with an empty chain
   a_chain_empty: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == hmg_pkg::ST_LOAD_RD) && (nl_ff == '0)) |-> (c_v == '0))
      else $error("search chain not empty at pass start");

   // results only come out of the remap output state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == hmg_pkg::ST_REMAP_OUT))
      else $error("unexpected result");

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
// testbench for histogram_matching_gml_unit: directed and random pixel streams
// drive the block; a scoreboard class predicts every remapped pixel
// depends on hmg_pkg and the design sources
`timescale 1ns / 1ps
`default_nettype none

class hist_match_scoreboard;
   longint unsigned src_bins[256];
   longint unsigned tgt_bins[256];
   longint unsigned src_total, tgt_total;
   logic [7:0]      map[256];
   bit              map_ready;
   logic [7:0]      expected_pixels[$];
   int              mismatches;

   function void clear_hist();
      for (int k = 0; k < 256; k++) begin
         src_bins[k] = 0;
         tgt_bins[k] = 0;
         map[k] = 8'd0;
      end
      src_total = 0;
      tgt_total = 0;
      map_ready = 0;
   endfunction

   function new();
      clear_hist();
      mismatches = 0;
   endfunction

   function void build_map();
      longint unsigned tcum, scum, a, b, d, best;
      int prev_end, last;
      tcum = 0;
      prev_end = -1;
      for (int k = 0; k < 256; k++) map[k] = 8'd0;
      map_ready = 1;
      if (src_total == 0 || tgt_total == 0) return;
      for (int i = 0; i < 256; i++) begin
         tcum += tgt_bins[i];
         if (tgt_bins[i] == 0) continue;
         a = tcum * src_total;
         best = tgt_total * src_total;
         last = prev_end;
         scum = 0;
         for (int j = 0; j < 256; j++) begin
            scum += src_bins[j];
            b = scum * tgt_total;
            d = (a >= b) ? a - b : b - a;
            if (d < best) begin
               best = d;
               last = j;
            end
         end
         for (int j = prev_end + 1; j <= last; j++) map[j] = i[7:0];
         prev_end = last;
      end
   endfunction

   // one accepted input transaction
   function void note_request(logic [1:0] mode, logic [7:0] pixel);
      case (mode)
         hmg_pkg::MODE_CLEAR: clear_hist();
         hmg_pkg::MODE_SRC: begin
            map_ready = 0;
            if (src_total < 64'd16777216) begin
               src_bins[pixel]++;
               src_total++;
            end
         end
         hmg_pkg::MODE_TGT: begin
            map_ready = 0;
            if (tgt_total < 64'd16777216) begin
               tgt_bins[pixel]++;
               tgt_total++;
            end
         end
         default: begin
            if (!map_ready) build_map();
            expected_pixels.push_back(map[pixel]);
         end
      endcase
   endfunction

   // one accepted result transaction
   function void check_result(logic [7:0] actual);
      logic [7:0] want;
      if (expected_pixels.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result: mapped_pixel %0d", actual);
         return;
      end
      want = expected_pixels.pop_front();
      if (actual !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mapped_pixel mismatch: expected %0d actual %0d", want, actual);
      end
   endfunction
endclass

module tb_top;

   localparam int WATCHDOG_LIMIT = 400000;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_valid = 0;
   logic       req_stall;
   logic [1:0] req_mode = hmg_pkg::MODE_CLEAR;
   logic [7:0] req_pixel = 0;
   logic       rsp_valid;
   logic       rsp_stall = 0;
   logic [7:0] rsp_mapped_pixel;

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  quiet_cycles = 0;
   int  items_sent = 0;
   bit  stimulus_done = 0;
   hist_match_scoreboard sb = new();

   histogram_matching_gml_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_mode(req_mode), .req_pixel(req_pixel),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_mapped_pixel(rsp_mapped_pixel)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_mode, req_pixel);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_mapped_pixel);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || stimulus_done)
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** histogram_matching_gml_unit: FAILED **");
            $finish;
         end
      end
   end

   task automatic send(input logic [1:0] mode, input logic [7:0] pixel);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_mode  <= mode;
      req_pixel <= pixel;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (items_sent == 450) begin
         send_idle_pct = 65;
         recv_stall_pct = 11;
      end else if (items_sent == 900) begin
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end
   endtask

   // one well-formed load and remap sequence, mostly over small pools of gray values
   task automatic run_group();
      logic [7:0] src_pool[16];
      logic [7:0] tgt_pool[];
      int n_src, n_tgt, n_cnt, n_remap, r;
      n_src = $urandom_range(1, 16);
      n_tgt = ($urandom_range(99) < 8) ? $urandom_range(64, 256) : $urandom_range(1, 12);
      tgt_pool = new[n_tgt];
      foreach (src_pool[k]) src_pool[k] = 8'($urandom_range(255));
      foreach (tgt_pool[k]) tgt_pool[k] = (n_tgt == 256) ? 8'(k) : 8'($urandom_range(255));
      if ($urandom_range(99) < 70) send(hmg_pkg::MODE_CLEAR, 8'($urandom_range(255)));
      n_cnt = $urandom_range(10, 40);
      for (int k = 0; k < n_cnt; k++) begin
         r = $urandom_range(99);
         if (r < 47) send(hmg_pkg::MODE_SRC, src_pool[$urandom_range(n_src - 1)]);
         else if (r < 94) send(hmg_pkg::MODE_TGT, tgt_pool[$urandom_range(n_tgt - 1)]);
         else if (r < 97) send(hmg_pkg::MODE_SRC, 8'($urandom_range(255)));
         else send(hmg_pkg::MODE_REMAP, 8'($urandom_range(255)));
      end
      n_remap = $urandom_range(5, 25);
      for (int k = 0; k < n_remap; k++)
         send(hmg_pkg::MODE_REMAP,
              ($urandom_range(1)) ? src_pool[$urandom_range(n_src - 1)]
                                  : 8'($urandom_range(255)));
   endtask

   initial begin
      int wait_cycles;
      send_idle_pct = 11;
      recv_stall_pct = 65;
      repeat (8) @(posedge clock);
      reset <= 0;

      // empty histograms, then a one-sided load, then loads at the extreme gray values, then a clear
      send(hmg_pkg::MODE_REMAP, 8'd0);
      send(hmg_pkg::MODE_REMAP, 8'd255);
      send(hmg_pkg::MODE_SRC, 8'd0);
      send(hmg_pkg::MODE_REMAP, 8'd0);
      send(hmg_pkg::MODE_TGT, 8'd255);
      send(hmg_pkg::MODE_REMAP, 8'd0);
      send(hmg_pkg::MODE_REMAP, 8'd255);
      send(hmg_pkg::MODE_SRC, 8'd255);
      send(hmg_pkg::MODE_TGT, 8'd0);
      send(hmg_pkg::MODE_REMAP, 8'd0);
      send(hmg_pkg::MODE_REMAP, 8'd255);
      send(hmg_pkg::MODE_REMAP, 8'd128);
      send(hmg_pkg::MODE_CLEAR, 8'd255);
      send(hmg_pkg::MODE_TGT, 8'd7);
      send(hmg_pkg::MODE_SRC, 8'd100);
      send(hmg_pkg::MODE_SRC, 8'd200);
      send(hmg_pkg::MODE_SRC, 8'd50);
      send(hmg_pkg::MODE_REMAP, 8'd200);
      send(hmg_pkg::MODE_REMAP, 8'd50);
      send(hmg_pkg::MODE_REMAP, 8'd99);
      send(hmg_pkg::MODE_REMAP, 8'd255);
      send(hmg_pkg::MODE_CLEAR, 8'd0);
      send(hmg_pkg::MODE_REMAP, 8'd100);

      while (items_sent < 1300) run_group();
      @(negedge clock);
      req_valid <= 0;

      wait_cycles = 0;
      while (sb.expected_pixels.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         wait_cycles++;
      end
      stimulus_done = 1;
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
         $display("** histogram_matching_gml_unit: PASSED **");
      else
         $display("** histogram_matching_gml_unit: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire

@@ files.f @@
design/hmg_pkg.sv
design/hmg_ram.sv
design/hmg_cell.sv
design/histogram_matching_gml_unit.sv
tb/sv/tb_top.sv
